FILE: sv/led_fire_heat_simulation_top_macros.svh
`ifndef LED_FIRE_HEAT_SIMULATION_TOP_MACROS_SVH
`define LED_FIRE_HEAT_SIMULATION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define LFHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lfhs_pkg.sv
package lfhs_pkg;

  localparam int unsigned MAX_PIXELS  = 64;
  localparam int unsigned PIX_W       = $clog2(MAX_PIXELS);
  localparam int unsigned LEN_W       = PIX_W + 1;
  localparam int unsigned HEAT_W      = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COLOR_W     = 8;

  localparam int unsigned PIX_FIELD_W = 6;
  localparam int unsigned OUT_PAY_W   = PIX_FIELD_W + 3 * COLOR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned LEN_CFG_W   = 7;

  localparam int unsigned DVD_W       = 16;
  localparam int unsigned DVS_W       = 8;
  localparam int unsigned DCNT_W      = $clog2(DVD_W);

  localparam logic [7:0]           COOLING_RST = 8'd55;
  localparam logic [7:0]           SPARK_RST   = 8'd120;
  localparam logic [LEN_CFG_W-1:0] LENGTH_RST  = 7'd64;

  localparam int unsigned COOL_MULT   = 10;
  localparam int unsigned FACTOR_OFS  = 2;
  localparam int unsigned FACTOR_MAX  = 255;
  localparam int unsigned SPARK_BASE  = 160;
  localparam int unsigned SPARK_MOD   = 95;
  localparam int unsigned PAL_MULT    = 191;
  localparam int unsigned DIV3_MUL    = 683;
  localparam int unsigned DIV3_SH     = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COOLING = 2'd0,
    CFG_SPARK   = 2'd1,
    CFG_BASE    = 2'd2,
    CFG_LENGTH  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  function automatic rgb_t heat_palette(input logic [HEAT_W-1:0] h);
    logic [15:0]        prod;
    logic [7:0]         t;
    logic [COLOR_W-1:0] ramp;
    rgb_t               c;
    prod = 16'(h) * 16'(PAL_MULT);
    t    = prod[15:8] + {7'd0, (h != '0)};
    ramp = {t[5:0], 2'b00};
    if (t[7]) begin
      c = '{red: 8'hFF, green: 8'hFF, blue: ramp};
    end else if (t[6]) begin
      c = '{red: 8'hFF, green: ramp, blue: 8'h00};
    end else begin
      c = '{red: ramp, green: 8'h00, blue: 8'h00};
    end
    return c;
  endfunction

  // floor(s / 3) for s below 768, by reciprocal multiply
  function automatic logic [HEAT_W-1:0] div3(input logic [HEAT_W+1:0] s);
    logic [20:0] p;
    p = 21'(s) * 21'(DIV3_MUL);
    return p[DIV3_SH+HEAT_W-1:DIV3_SH];
  endfunction

  function automatic logic [6:0] mod95(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    if (b >= BYTE_W'(2 * SPARK_MOD)) begin
      r = b - BYTE_W'(2 * SPARK_MOD);
    end else if (b >= BYTE_W'(SPARK_MOD)) begin
      r = b - BYTE_W'(SPARK_MOD);
    end else begin
      r = b;
    end
    return r[6:0];
  endfunction

  function automatic logic [PIX_W-1:0] phys_cell(input logic [LEN_W-1:0] k,
                                                 input logic [LEN_W-1:0] n,
                                                 input logic             base);
    logic [LEN_W-1:0] m;
    m = n - k - LEN_W'(1);
    return base ? k[PIX_W-1:0] : m[PIX_W-1:0];
  endfunction

endpackage

FILE: sv/led_fire_heat_simulation_top.sv
// Fire effect for one LED strip, fed by a stream of 32-bit random words.
// Input stream (s_axis): one random word per transaction. While a frame is
// cooling, each word cools cells from the fire base, one cell per byte
// from the low end, until the bytes left are zero or every cell is cooled;
// such a word produces no output. The next word is the spark word: it
// diffuses heat away from the base, may ignite a spark, and emits every
// cell as a heat-palette color on m_axis, pixel 0 first, tlast on the last.
// Config port: index 0 cooling_rate, 1 spark_chance, 2 base_at_start,
// 3 strip_length; always ready, write only while the block is idle.
// Sequence: a cooling word first gets its cooling factor from the serial
// divider, then runs one divide per byte used. A spark word diffuses heat
// (one heat memory read per cycle), uses the divider again if a spark
// ignites, then emits one pixel per cycle on m_axis while the receiver
// is ready. One word is worked on at a time.
// Reset clears the heat store, the frame position and loads the register
// defaults. A stalled receiver holds the output register and stops the
// emission; the next input word is taken once the last pixel is loaded.
`include "led_fire_heat_simulation_top_macros.svh"

module led_fire_heat_simulation_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [lfhs_pkg::WORD_W-1:0]        s_axis_tdata_i,   // random_word
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // pixel_index, red, green, blue
  output logic [lfhs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tlast_o,   // last_pixel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lfhs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lfhs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_FACT     = 9'b000000010,
    ST_CL_START = 9'b000000100,
    ST_CL_DIV   = 9'b000001000,
    ST_DIFF     = 9'b000010000,
    ST_SP_DIV   = 9'b000100000,
    ST_SP_WR    = 9'b001000000,
    ST_EM_RD    = 9'b010000000,
    ST_EM_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]                       cooling_q, spark_q;
  logic                             base_q;
  logic [lfhs_pkg::LEN_CFG_W-1:0]   length_q;
  logic                             cfg_fire;

  logic [lfhs_pkg::LEN_W-1:0]       n_live;
  logic [lfhs_pkg::LEN_W-1:0]       n_q, n_d;
  logic [lfhs_pkg::LEN_W-1:0]       cool_pos_q, cool_pos_d;
  logic [lfhs_pkg::WORD_W-1:0]      residue_q, residue_d;
  logic [7:0]                       factor_q, factor_d;
  logic [lfhs_pkg::LEN_W-1:0]       k_q, k_d;
  logic [lfhs_pkg::HEAT_W-1:0]      h1_q, h1_d, h2_q, h2_d;
  logic [lfhs_pkg::PIX_W-1:0]       sp_addr_q, sp_addr_d;
  logic [lfhs_pkg::PIX_W-1:0]       emit_q, emit_d;

  logic                             ram_we, ram_re;
  logic [lfhs_pkg::PIX_W-1:0]       ram_waddr, ram_raddr;
  logic [lfhs_pkg::HEAT_W-1:0]      ram_wdata, ram_rdata, heat_rd;
  logic [lfhs_pkg::MAX_PIXELS-1:0]  valid_q;
  logic                             rd_valid_q;

  lfhs_pkg::div_req_t               div_req;
  lfhs_pkg::div_rsp_t               div_rsp;

  logic                             s_fire;
  logic                             out_load, out_last_d, emit_last;
  logic                             out_valid_q;
  logic [lfhs_pkg::PIX_FIELD_W-1:0] out_pix_q;
  lfhs_pkg::rgb_t                   out_rgb_q;
  logic                             out_last_q;
  logic [8:0]                       spark_sum;
  logic [7:0]                       spark_add;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooling_q <= lfhs_pkg::COOLING_RST;
      spark_q   <= lfhs_pkg::SPARK_RST;
      base_q    <= 1'b1;
      length_q  <= lfhs_pkg::LENGTH_RST;
    end else if (cfg_fire) begin
      unique case (lfhs_pkg::cfg_idx_e'(cfg_index_i))
        lfhs_pkg::CFG_COOLING: cooling_q <= cfg_data_i;
        lfhs_pkg::CFG_SPARK:   spark_q   <= cfg_data_i;
        lfhs_pkg::CFG_BASE:    base_q    <= cfg_data_i[0];
        lfhs_pkg::CFG_LENGTH:  length_q  <= cfg_data_i[lfhs_pkg::LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (length_q == '0) begin
      n_live = lfhs_pkg::LEN_W'(1);
    end else if (length_q > lfhs_pkg::LEN_CFG_W'(lfhs_pkg::MAX_PIXELS)) begin
      n_live = lfhs_pkg::LEN_W'(lfhs_pkg::MAX_PIXELS);
    end else begin
      n_live = lfhs_pkg::LEN_W'(length_q);
    end
  end

  // ------------------------------------------------------------- heat store
  lfhs_ram #(
    .WIDTH (lfhs_pkg::HEAT_W),
    .DEPTH (lfhs_pkg::MAX_PIXELS)
  ) u_heat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // cells never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
    end
  end

  assign heat_rd = rd_valid_q ? ram_rdata : '0;

  lfhs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ------------------------------------------------------------ sequencer
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign emit_last       = (lfhs_pkg::LEN_W'(emit_q) == n_q - lfhs_pkg::LEN_W'(1));

  assign spark_add = 8'(lfhs_pkg::SPARK_BASE) + {1'b0, lfhs_pkg::mod95(residue_q[31:24])};
  assign spark_sum = {1'b0, heat_rd} + {1'b0, spark_add};

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    cool_pos_d = cool_pos_q;
    residue_d  = residue_q;
    factor_d   = factor_q;
    k_d        = k_q;
    h1_d       = h1_q;
    h2_d       = h2_q;
    sp_addr_d  = sp_addr_q;
    emit_d     = emit_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    div_req    = '0;
    out_load   = 1'b0;
    out_last_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          residue_d = s_axis_tdata_i;
          n_d       = n_live;
          if (cool_pos_q < n_live) begin
            div_req.start    = 1'b1;
            div_req.dividend = 16'(cooling_q) * 16'(lfhs_pkg::COOL_MULT);
            div_req.divisor  = lfhs_pkg::DVS_W'(n_live);
            state_d          = ST_FACT;
          end else begin
            k_d     = '0;
            state_d = ST_DIFF;
          end
        end
      end

      ST_FACT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot >= lfhs_pkg::DVD_W'(lfhs_pkg::FACTOR_MAX - lfhs_pkg::FACTOR_OFS))
          begin
            factor_d = 8'(lfhs_pkg::FACTOR_MAX);
          end else begin
            factor_d = div_rsp.quot[7:0] + 8'(lfhs_pkg::FACTOR_OFS);
          end
          state_d = ST_CL_START;
        end
      end

      ST_CL_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = lfhs_pkg::DVD_W'(residue_q[7:0]);
        div_req.divisor  = factor_q;
        ram_re           = 1'b1;
        ram_raddr        = lfhs_pkg::phys_cell(cool_pos_q, n_q, base_q);
        state_d          = ST_CL_DIV;
      end

      ST_CL_DIV: begin
        if (div_rsp.done) begin
          ram_we     = 1'b1;
          ram_waddr  = lfhs_pkg::phys_cell(cool_pos_q, n_q, base_q);
          ram_wdata  = (heat_rd > div_rsp.rem) ? heat_rd - div_rsp.rem : '0;
          residue_d  = residue_q >> 8;
          cool_pos_d = cool_pos_q + lfhs_pkg::LEN_W'(1);
          if ((residue_q[31:8] != '0) && (cool_pos_d < n_q)) begin
            state_d = ST_CL_START;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      // old cells read upward from the base; each write lands on the cell
      // whose old value has just been read
      ST_DIFF: begin
        if (k_q < n_q) begin
          ram_re    = 1'b1;
          ram_raddr = lfhs_pkg::phys_cell(k_q, n_q, base_q);
        end
        if (k_q != '0) begin
          h1_d = heat_rd;
          h2_d = h1_q;
          if (k_q >= lfhs_pkg::LEN_W'(3)) begin
            ram_we    = 1'b1;
            ram_waddr = lfhs_pkg::phys_cell(k_q - lfhs_pkg::LEN_W'(1), n_q, base_q);
            ram_wdata = lfhs_pkg::div3({2'b00, h1_q} + {1'b0, h2_q, 1'b0});
          end
        end
        k_d = k_q + lfhs_pkg::LEN_W'(1);
        if (k_q == n_q) begin
          emit_d = '0;
          if (residue_q[7:0] < spark_q) begin
            div_req.start    = 1'b1;
            div_req.dividend = residue_q[23:8];
            div_req.divisor  = lfhs_pkg::DVS_W'(n_q);
            state_d          = ST_SP_DIV;
          end else begin
            state_d = ST_EM_RD;
          end
        end
      end

      ST_SP_DIV: begin
        if (div_rsp.done) begin
          sp_addr_d = lfhs_pkg::phys_cell(div_rsp.rem[lfhs_pkg::LEN_W-1:0], n_q, base_q);
          ram_re    = 1'b1;
          ram_raddr = sp_addr_d;
          state_d   = ST_SP_WR;
        end
      end

      ST_SP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sp_addr_q;
        ram_wdata = spark_sum[8] ? 8'hFF : spark_sum[7:0];
        emit_d    = '0;
        state_d   = ST_EM_RD;
      end

      ST_EM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = emit_q;
        state_d   = ST_EM_OUT;
      end

      ST_EM_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load   = 1'b1;
          out_last_d = emit_last;
          if (emit_last) begin
            cool_pos_d = '0;
            state_d    = ST_IDLE;
          end else begin
            emit_d    = emit_q + lfhs_pkg::PIX_W'(1);
            ram_re    = 1'b1;
            ram_raddr = emit_d;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cool_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cool_pos_q  <= cool_pos_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    residue_q <= residue_d;
    factor_q  <= factor_d;
    k_q       <= k_d;
    h1_q      <= h1_d;
    h2_q      <= h2_d;
    sp_addr_q <= sp_addr_d;
    emit_q    <= emit_d;
    if (out_load) begin
      out_pix_q  <= lfhs_pkg::PIX_FIELD_W'(emit_q);
      out_rgb_q  <= lfhs_pkg::heat_palette(heat_rd);
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = lfhs_pkg::OUT_TDATA_W'({out_rgb_q.blue, out_rgb_q.green,
                                                   out_rgb_q.red, out_pix_q});
  assign m_axis_tlast_o  = out_last_q;

  // ------------------------------------------------------------ assertions
  `LFHS_ASSERT_IMP(a_rw_disjoint, ram_we && ram_re, ram_waddr != ram_raddr,
                   "heat store read and write hit the same cell")
  `LFHS_ASSERT_IMP(a_div_free_idle, s_axis_tready_o, !div_rsp.busy,
                   "divider busy while taking a new word")
  `LFHS_ASSERT_IMP(a_div_done_wait, div_rsp.done,
                   (state_q == ST_FACT) || (state_q == ST_CL_DIV) || (state_q == ST_SP_DIV),
                   "divider result arrived outside a wait state")
  `LFHS_ASSERT_IMP(a_emit_range, state_q == ST_EM_OUT, lfhs_pkg::LEN_W'(emit_q) < n_q,
                   "emission index beyond strip length")
  `LFHS_ASSERT_NXT(a_last_to_idle, out_load && out_last_d,
                   (state_q == ST_IDLE) && (cool_pos_q == '0),
                   "frame end did not return to idle")

endmodule

FILE: sv/lfhs_ram.sv
module lfhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lfhs_div.sv
module lfhs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfhs_pkg::div_req_t  req_i,
  output lfhs_pkg::div_rsp_t  rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [lfhs_pkg::DCNT_W-1:0]  cnt_q, cnt_d;
  logic [lfhs_pkg::DVD_W-1:0]   dvd_q, dvd_d;
  logic [lfhs_pkg::DVS_W-1:0]   dvs_q, dvs_d;
  logic [lfhs_pkg::DVS_W-1:0]   rem_q, rem_d;
  logic [lfhs_pkg::DVS_W:0]     trial;
  logic                         qbit;

  // one quotient bit per cycle, quotient shifts in behind the dividend
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[lfhs_pkg::DVD_W-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? lfhs_pkg::DVS_W'(trial - {1'b0, dvs_q})
                   : lfhs_pkg::DVS_W'(trial);
      dvd_d = {dvd_q[lfhs_pkg::DVD_W-2:0], qbit};
      cnt_d = cnt_q + lfhs_pkg::DCNT_W'(1);
      if (cnt_q == lfhs_pkg::DCNT_W'(lfhs_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule
